FILE: sv/mppc_pkg.sv
// Package for the MPPC-style LZ decompressor.
// Holds the item type, op, status, phase and token codes, and history constants.
// Has no dependencies.
package mppc_pkg;

  // One queued input item.
  typedef struct packed {
    logic       op;
    logic [7:0] packed_byte;
  } item_t;

  // Input operation codes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_CONT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  // Parse phases.
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_FIELD  = 3'd1;
  localparam logic [2:0] PH_UNARY  = 3'd3;
  localparam logic [2:0] PH_LENGTH = 3'd4;

  // Token kinds.
  localparam logic [2:0] TK_LIT_LO  = 3'd1;
  localparam logic [2:0] TK_LIT_HI  = 3'd2;
  localparam logic [2:0] TK_OFF_13  = 3'd3;
  localparam logic [2:0] TK_OFF_8   = 3'd4;
  localparam logic [2:0] TK_OFF_6   = 3'd5;

  // History trim thresholds and offset biases.
  localparam logic [31:0] FILL_TRIM_AT = 32'd10240;
  localparam logic [31:0] FILL_TRIM_BY = 32'd2048;
  localparam logic [13:0] BIAS_OFF_13  = 14'h140;
  localparam logic [13:0] BIAS_OFF_8   = 14'h040;
  localparam logic [16:0] COPY_SIZE    = 17'd3;

endpackage

FILE: sv/mppc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the history ring and the result buffer.
module mppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

FILE: sv/mppc_front.sv
// Front end of the decompressor: accepts input items into a two-entry queue.
// Depends on mppc_pkg for the item type.
module mppc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           op,
  input  logic [7:0]     packed_byte,
  output logic           q_valid,
  output mppc_pkg::item_t q_item,
  input  logic           q_pop
);
  import mppc_pkg::*;

  item_t      ent [2];
  logic       rdp;
  logic       wrp;
  logic [1:0] fill;
  logic       push;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = ent[rdp];

  // Queue storage; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wrp] <= '{op: op, packed_byte: packed_byte};
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      rdp  <= 1'b0;
      wrp  <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wrp <= ~wrp;
      end
      if (q_pop) begin
        rdp <= ~rdp;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: sv/mppc_back.sv
// Back end of the decompressor: bit parser, copy engine and result drain.
// Depends on mppc_pkg and mppc_ram (history ring and result buffer).
module mppc_back #(
  parameter int HISTORY_DEPTH = 16384,
  parameter int MAX_CHUNK     = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mppc_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            more_pending,
  output logic [1:0]      status
);
  import mppc_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int RD = (MAX_CHUNK > 1) ? MAX_CHUNK : 2;
  localparam int RW = $clog2(RD);
  localparam int CW = $clog2(MAX_CHUNK + 1);
  localparam logic [CW-1:0] CHUNK = CW'(MAX_CHUNK);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_PARSE = 7'b0000100,
    S_CRD   = 7'b0001000,
    S_CWR   = 7'b0010000,
    S_DRD   = 7'b0100000,
    S_DOUT  = 7'b1000000
  } state_t;

  state_t        state, state_next;
  item_t         item, item_next;
  logic [23:0]   bbuf, bbuf_next;
  logic [4:0]    cnt, cnt_next;
  logic [2:0]    phase, phase_next;
  logic [2:0]    kind, kind_next;
  logic [13:0]   moff, moff_next;
  logic [4:0]    ones, ones_next;
  logic [AW-1:0] wp, wp_next;
  logic [31:0]   fill, fill_next;
  logic [16:0]   rem, rem_next;
  logic          stalled, stalled_next;
  logic [CW-1:0] resn, resn_next;
  logic [CW-1:0] didx, didx_next;

  logic          hwe;
  logic [7:0]    hwd;
  logic [7:0]    hrd;
  logic          rwe;
  logic [9:0]    rwd;
  logic [9:0]    rrd;

  logic [4:0]    need;
  logic [4:0]    size;
  logic [3:0]    top4;
  logic [15:0]   fv;
  logic [23:0]   frest;
  logic [15:0]   lv;
  logic [23:0]   lrest;
  logic [13:0]   offv;
  logic [16:0]   len;

  // Value of the n oldest buffered bits.
  function automatic logic [15:0] take_val(logic [23:0] b, logic [4:0] c, logic [4:0] n);
    logic [23:0] sh;
    sh = b >> (c - n);
    return 16'(sh & ((24'd1 << n) - 24'd1));
  endfunction

  // Buffer left after taking n bits.
  function automatic logic [23:0] take_rest(logic [23:0] b, logic [4:0] c, logic [4:0] n);
    return b & ((24'd1 << (c - n)) - 24'd1);
  endfunction

  // History ring and per-item result buffer.
  mppc_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(hwe), .wa(wp), .wd(hwd), .ra(wp - AW'(moff)), .rd(hrd)
  );

  mppc_ram #(.WIDTH(10), .DEPTH(RD)) u_res (
    .clk(clk), .we(rwe), .wa(resn[RW-1:0]), .wd(rwd), .ra(didx[RW-1:0]), .rd(rrd)
  );

  // Field decode helpers.
  always_comb begin
    top4 = 4'(take_val(bbuf, cnt, 5'd4));
    unique case (kind)
      TK_OFF_13: need = 5'd13;
      TK_OFF_8:  need = 5'd8;
      TK_OFF_6:  need = 5'd6;
      default:   need = 5'd7;
    endcase
    fv    = take_val(bbuf, cnt, need);
    frest = take_rest(bbuf, cnt, need);
    unique case (kind)
      TK_OFF_13: offv = 14'(fv) + BIAS_OFF_13;
      TK_OFF_8:  offv = 14'(fv) + BIAS_OFF_8;
      default:   offv = 14'(fv);
    endcase
    size  = ones + 5'd1;
    lv    = take_val(bbuf, cnt, size);
    lrest = take_rest(bbuf, cnt, size);
    len   = (ones == 5'd0) ? COPY_SIZE : 17'(lv) + (17'd1 << size);
  end

  // Sequencer next-state logic.
  always_comb begin
    state_next   = state;
    item_next    = item;
    bbuf_next    = bbuf;
    cnt_next     = cnt;
    phase_next   = phase;
    kind_next    = kind;
    moff_next    = moff;
    ones_next    = ones;
    wp_next      = wp;
    fill_next    = fill;
    rem_next     = rem;
    stalled_next = stalled;
    resn_next    = resn;
    didx_next    = didx;
    hwe          = 1'b0;
    hwd          = hrd;
    rwe          = 1'b0;
    rwd          = {ST_OK, hrd};
    q_pop        = 1'b0;

    unique case (state)
      S_IDLE: begin
        resn_next = '0;
        didx_next = '0;
        if (q_valid) begin
          q_pop      = 1'b1;
          item_next  = q_item;
          state_next = S_START;
        end
      end

      S_START: begin
        if (item.op == OP_CONT) begin
          state_next = S_CRD;
        end else if (rem != 17'd0 || stalled) begin
          rwe        = 1'b1;
          rwd        = {ST_REJECT, 8'd0};
          resn_next  = resn + CW'(1);
          state_next = S_DRD;
        end else begin
          bbuf_next  = {bbuf[15:0], item.packed_byte};
          cnt_next   = cnt + 5'd8;
          if (fill >= FILL_TRIM_AT) begin
            fill_next = fill - FILL_TRIM_BY;
          end
          state_next = S_PARSE;
        end
      end

      // Copy engine: read a history byte, then write it back and record it.
      S_CRD: begin
        if (rem != 17'd0 && resn < CHUNK) begin
          state_next = S_CWR;
        end else if (rem == 17'd0) begin
          stalled_next = 1'b0;
          state_next   = S_PARSE;
        end else begin
          state_next = S_DRD;
        end
      end

      S_CWR: begin
        hwe       = 1'b1;
        hwd       = hrd;
        rwe       = 1'b1;
        rwd       = {ST_OK, hrd};
        wp_next   = wp + AW'(1);
        fill_next = (fill == 32'hFFFF_FFFF) ? fill : fill + 32'd1;
        rem_next  = rem - 17'd1;
        resn_next = resn + CW'(1);
        state_next = S_CRD;
      end

      // One parse step per cycle.
      S_PARSE: begin
        if (resn >= CHUNK) begin
          stalled_next = 1'b1;
          state_next   = S_DRD;
        end else begin
          unique case (phase)
            PH_PREFIX: begin
              if (cnt < 5'd4) begin
                state_next = S_DRD;
              end else begin
                phase_next = PH_FIELD;
                priority casez (top4)
                  4'b0???: begin
                    kind_next = TK_LIT_LO;
                    bbuf_next = take_rest(bbuf, cnt, 5'd1);
                    cnt_next  = cnt - 5'd1;
                  end
                  4'b10??: begin
                    kind_next = TK_LIT_HI;
                    bbuf_next = take_rest(bbuf, cnt, 5'd2);
                    cnt_next  = cnt - 5'd2;
                  end
                  4'b110?: begin
                    kind_next = TK_OFF_13;
                    bbuf_next = take_rest(bbuf, cnt, 5'd3);
                    cnt_next  = cnt - 5'd3;
                  end
                  4'b1110: begin
                    kind_next = TK_OFF_8;
                    bbuf_next = take_rest(bbuf, cnt, 5'd4);
                    cnt_next  = cnt - 5'd4;
                  end
                  default: begin
                    kind_next = TK_OFF_6;
                    bbuf_next = take_rest(bbuf, cnt, 5'd4);
                    cnt_next  = cnt - 5'd4;
                  end
                endcase
              end
            end

            PH_FIELD: begin
              if (cnt < need) begin
                state_next = S_DRD;
              end else begin
                bbuf_next  = frest;
                cnt_next   = cnt - need;
                phase_next = PH_PREFIX;
                if (kind == TK_LIT_LO || kind == TK_LIT_HI) begin
                  // Literal byte goes to history and to the results.
                  hwe       = 1'b1;
                  hwd       = {(kind == TK_LIT_HI), fv[6:0]};
                  rwe       = 1'b1;
                  rwd       = {ST_OK, hwd};
                  wp_next   = wp + AW'(1);
                  fill_next = (fill == 32'hFFFF_FFFF) ? fill : fill + 32'd1;
                  resn_next = resn + CW'(1);
                end else if (offv == 14'd0) begin
                  // Zero offset: drop the rest of the current byte.
                  cnt_next  = (cnt - need) & 5'b11000;
                  bbuf_next = frest & ((24'd1 << ((cnt - need) & 5'b11000)) - 24'd1);
                end else begin
                  moff_next  = offv;
                  ones_next  = 5'd0;
                  phase_next = PH_UNARY;
                end
              end
            end

            PH_UNARY: begin
              if (cnt == 5'd0) begin
                state_next = S_DRD;
              end else begin
                bbuf_next = take_rest(bbuf, cnt, 5'd1);
                cnt_next  = cnt - 5'd1;
                if (take_val(bbuf, cnt, 5'd1) == 16'd0) begin
                  phase_next = PH_LENGTH;
                end else if (ones == 5'd15) begin
                  rwe        = 1'b1;
                  rwd        = {ST_BAD_LEN, 8'd0};
                  resn_next  = resn + CW'(1);
                  ones_next  = 5'd0;
                  phase_next = PH_PREFIX;
                end else begin
                  ones_next = ones + 5'd1;
                end
              end
            end

            PH_LENGTH: begin
              if (ones != 5'd0 && cnt < size) begin
                state_next = S_DRD;
              end else begin
                if (ones != 5'd0) begin
                  bbuf_next = lrest;
                  cnt_next  = cnt - size;
                end
                phase_next = PH_PREFIX;
                rem_next   = (fill < 32'(moff)) ? 17'd0 : len;
                state_next = S_CRD;
              end
            end

            default: phase_next = PH_PREFIX;
          endcase
        end
      end

      // Drain the results of the item.
      S_DRD: begin
        state_next = (resn == '0) ? S_IDLE : S_DOUT;
      end

      S_DOUT: begin
        if (!out_stall) begin
          if (didx == resn - CW'(1)) begin
            state_next = S_IDLE;
          end else begin
            didx_next  = didx + CW'(1);
            state_next = S_DRD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Result port.
  assign out_valid    = (state == S_DOUT);
  assign out_byte     = rrd[7:0];
  assign status       = rrd[9:8];
  assign last         = (didx == resn - CW'(1));
  assign more_pending = (rem != 17'd0) || stalled;

  // Item payload register.
  always_ff @(posedge clk) begin
    item <= item_next;
  end

  // Control and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bbuf    <= '0;
      cnt     <= '0;
      phase   <= PH_PREFIX;
      kind    <= '0;
      moff    <= '0;
      ones    <= '0;
      wp      <= '0;
      fill    <= '0;
      rem     <= '0;
      stalled <= 1'b0;
      resn    <= '0;
      didx    <= '0;
    end else begin
      state   <= state_next;
      bbuf    <= bbuf_next;
      cnt     <= cnt_next;
      phase   <= phase_next;
      kind    <= kind_next;
      moff    <= moff_next;
      ones    <= ones_next;
      wp      <= wp_next;
      fill    <= fill_next;
      rem     <= rem_next;
      stalled <= stalled_next;
      resn    <= resn_next;
      didx    <= didx_next;
    end
  end

endmodule

FILE: sv/mppc_variant_lz_decompressor.sv
// Top level of the MPPC-style LZ decompressor.
// Depends on mppc_pkg, mppc_front (input queue) and mppc_back (parser and copy engine).
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   op, packed_byte
//   output   out_valid / out_stall out_byte, last, more_pending, status
//
// Each item passes through setup (S_IDLE, S_START) and then parse steps; each copied
// byte takes a history read then a write-back (S_CRD, S_CWR), and each delivered result
// a result-buffer read then an output transfer (S_DRD, S_DOUT). Reset (rst, synchronous)
// clears all control state; the history ring needs no clearing. A stall on the output
// holds the current result. The two-entry input queue keeps accepting while the back
// end works, until it is full.
module mppc_variant_lz_decompressor #(
  parameter int HISTORY_DEPTH = 16384,
  parameter int MAX_CHUNK     = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] packed_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       more_pending,
  output logic [1:0] status
);
  import mppc_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  mppc_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .packed_byte(packed_byte),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  mppc_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .MAX_CHUNK(MAX_CHUNK)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last(last), .more_pending(more_pending), .status(status)
  );

endmodule

FILE: test/testbench.sv
// Testbench for mppc_variant_lz_decompressor: directed and random compressed streams.
// Depends on mppc_pkg and the decompressor RTL; a scoreboard class predicts every byte.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mppc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       pend;
    logic [1:0] status;
  } result_t;

  // Scoreboard: a bit-level copy of the decompressor and the queue of bytes it predicts.
  class lz_scoreboard;
    logic [7:0]  ring [16384];
    int unsigned buf_bits, buf_cnt, phase, kind, offset, ones, wptr, fill, remain;
    bit          held;
    int          errors;
    result_t     due[$];
    result_t     cur[$];

    function new();
      buf_bits = 0; buf_cnt = 0; phase = PH_PREFIX; kind = 0; offset = 0; ones = 0;
      wptr = 0; fill = 0; remain = 0; held = 0; errors = 0;
    endfunction

    function bit pending();
      return (remain > 0) || held;
    endfunction

    function int unsigned take(int unsigned n);
      int unsigned v;
      v = (buf_bits >> (buf_cnt - n)) & ((1 << n) - 1);
      buf_cnt -= n;
      buf_bits &= (1 << buf_cnt) - 1;
      return v;
    endfunction

    function void put(logic [7:0] b, logic [1:0] st);
      result_t r;
      r.data = b; r.last = 0; r.pend = 0; r.status = st;
      cur.insert(cur.size(), r);
    endfunction

    function void out_byte_hist(logic [7:0] b);
      ring[wptr] = b;
      wptr = (wptr + 1) % 16384;
      if (fill != 32'hFFFF_FFFF) fill++;
      put(b, ST_OK);
    endfunction

    function void run_copy();
      while (remain > 0 && cur.size() < 64) begin
        out_byte_hist(ring[(wptr + 16384 - (offset % 16384)) % 16384]);
        remain--;
      end
    endfunction

    // Parse tokens until bits run out, a copy stalls or the chunk limit is hit.
    function void decode();
      int unsigned need, v, len;
      forever begin
        if (cur.size() >= 64) begin
          held = 1;
          return;
        end
        if (phase == PH_PREFIX) begin
          if (buf_cnt < 4) return;
          if (take(1) == 0) kind = TK_LIT_LO;
          else if (take(1) == 0) kind = TK_LIT_HI;
          else if (take(1) == 0) kind = TK_OFF_13;
          else if (take(1) == 0) kind = TK_OFF_8;
          else kind = TK_OFF_6;
          phase = PH_FIELD;
        end else if (phase == PH_FIELD) begin
          need = (kind == TK_OFF_13) ? 13 : (kind == TK_OFF_8) ? 8 : (kind == TK_OFF_6) ? 6 : 7;
          if (buf_cnt < need) return;
          v = take(need);
          phase = PH_PREFIX;
          if (kind == TK_LIT_LO) out_byte_hist(8'(v));
          else if (kind == TK_LIT_HI) out_byte_hist(8'(v | 8'h80));
          else begin
            if (kind == TK_OFF_13) v += BIAS_OFF_13;
            else if (kind == TK_OFF_8) v += BIAS_OFF_8;
            if (v == 0) begin
              // A zero offset realigns to the next byte boundary.
              buf_cnt -= buf_cnt % 8;
              buf_bits &= (1 << buf_cnt) - 1;
            end else begin
              offset = v;
              ones = 0;
              phase = PH_UNARY;
            end
          end
        end else if (phase == PH_UNARY) begin
          if (buf_cnt < 1) return;
          if (take(1) == 0) phase = PH_LENGTH;
          else begin
            ones++;
            if (ones >= 16) begin
              put(8'd0, ST_BAD_LEN);
              ones = 0;
              phase = PH_PREFIX;
            end
          end
        end else if (phase == PH_LENGTH) begin
          len = COPY_SIZE;
          if (ones != 0) begin
            if (buf_cnt < ones + 1) return;
            len = take(ones + 1) + (1 << (ones + 1));
          end
          phase = PH_PREFIX;
          // A copy reaching beyond the history is dropped whole.
          if (fill < offset) len = 0;
          remain = len;
          run_copy();
          if (remain > 0) return;
        end else phase = PH_PREFIX;
      end
    endfunction

    // Note one accepted input transfer and queue the results it causes.
    function void note_input(logic o, logic [7:0] b);
      cur.delete();
      if (o == OP_DATA) begin
        if (pending()) begin
          put(8'd0, ST_REJECT);
          cur[0].last = 1;
          cur[0].pend = 1;
          due.insert(due.size(), cur[0]);
          return;
        end
        buf_bits = ((buf_bits << 8) | b) & 24'hFFFFFF;
        buf_cnt += 8;
        if (fill >= FILL_TRIM_AT) fill -= FILL_TRIM_BY;
        decode();
      end else begin
        run_copy();
        if (remain == 0) begin
          held = 0;
          decode();
        end
      end
      foreach (cur[i]) begin
        cur[i].pend = pending();
        cur[i].last = (i == cur.size() - 1);
        due.insert(due.size(), cur[i]);
      end
    endfunction

    // Compare one output transfer with the oldest predicted result.
    function void check_result(result_t got);
      result_t w;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte %h status %0d", $time, got.data, got.status);
        return;
      end
      w = due.pop_front();
      if (got.data !== w.data) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, w.data, got.data);
      end
      if (got.last !== w.last) begin
        errors++;
        $display("%0t: last expected %b actual %b", $time, w.last, got.last);
      end
      if (got.pend !== w.pend) begin
        errors++;
        $display("%0t: more_pending expected %b actual %b", $time, w.pend, got.pend);
      end
      if (got.status !== w.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
      end
    endfunction
  endclass

  logic       clk = 0, rst = 1;
  logic       in_valid = 0, op = OP_DATA;
  logic [7:0] packed_byte = 0;
  logic       out_stall = 0;
  logic       in_stall, out_valid, last, more_pending;
  logic [7:0] out_byte;
  logic [1:0] status;

  lz_scoreboard sb = new();
  bit           bitq[$];
  int           sent = 0, idle = 0, stall_left = 0;
  bit           in_quiet = 0, out_quiet = 0;

  mppc_variant_lz_decompressor DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .packed_byte(packed_byte), .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last(last), .more_pending(more_pending), .status(status)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Send one transfer after a random gap; the prediction is made on acceptance.
  task automatic send(logic o, logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    op <= o;
    packed_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(o, b);
    sent++;
    if ($urandom_range(0, 40) == 0) in_quiet = !in_quiet;
  endtask

  task automatic push_bits(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) bitq.insert(bitq.size(), v[i]);
  endtask

  // Send the whole bytes waiting in the bit queue, draining copies in between.
  task automatic flush_bytes();
    logic [7:0] b;
    while (bitq.size() >= 8) begin
      while (sb.pending()) send(OP_CONT, 8'd0);
      for (int i = 0; i < 8; i++) b[7 - i] = bitq.pop_front();
      send(OP_DATA, b);
    end
  endtask

  // Append a copy token: offset code then length code with k leading ones.
  task automatic push_copy(int unsigned off, int k, int unsigned v);
    if (off < 64) push_bits({4'b1111, off[5:0]}, 10);
    else if (off < 320) push_bits({4'b1110, 8'(off - 64)}, 12);
    else push_bits({3'b110, 13'(off - 320)}, 16);
    if (k == 0) push_bits(0, 1);
    else begin
      push_bits((1 << k) - 1, k);
      push_bits(0, 1);
      push_bits(v, k + 1);
    end
  endtask

  task automatic random_token();
    int unsigned r, lim, off;
    int k;
    r = $urandom_range(0, 99);
    lim = (sb.fill < 8511) ? sb.fill : 8511;
    if (r < 10) push_bits($urandom, 8);
    else if (r < 30 || lim < 1) push_bits({1'b0, 7'($urandom)}, 8);
    else if (r < 50) push_bits({2'b10, 7'($urandom)}, 9);
    else begin
      off = (r < 55) ? lim + $urandom_range(1, 50) : $urandom_range(1, lim);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
      push_copy(off, k, $urandom);
    end
  endtask

  // Output side: check each transfer and draw a stall before the next.
  always @(posedge clk) begin
    int n;
    result_t r;
    if (!rst) begin
      n = stall_left;
      if (out_valid && !out_stall) begin
        r.data = out_byte; r.last = last; r.pend = more_pending; r.status = status;
        sb.check_result(r);
        n = out_quiet ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 50) == 0) out_quiet = !out_quiet;
      end
      if (n > 0) begin
        out_stall <= 1;
        stall_left <= n - 1;
      end else begin
        out_stall <= 0;
        stall_left <= 0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle <= 0;
      else idle <= idle + 1;
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (idle >= 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Continue with nothing pending, then literals at both extremes.
    send(OP_CONT, 8'hFF);
    push_bits({1'b0, 7'h00}, 8);
    push_bits({1'b0, 7'h7F}, 8);
    push_bits({2'b10, 7'h00}, 9);
    push_bits({2'b10, 7'h7F}, 9);
    push_bits({1'b0, 7'h55}, 8);
    // Short copy, then a zero offset that realigns to a byte boundary.
    push_copy(1, 0, 0);
    push_bits(6'b111100, 6);
    push_bits({4'b1111, 6'd0}, 10);
    flush_bytes();
    // Copies past the history on all three offset forms.
    push_copy(40, 1, 3);
    push_copy(300, 0, 0);
    push_copy(8511, 2, 0);
    // Length prefix of sixteen ones is an error.
    push_bits({4'b1111, 6'd2}, 10);
    push_bits(16'hFFFF, 16);
    push_bits(0, 6);
    flush_bytes();
    // A long copy spanning many chunks, with a data byte sent while pending.
    push_copy(3, 12, 2100);
    push_bits(0, 6);
    while (bitq.size() >= 8) begin
      logic [7:0] b;
      for (int i = 0; i < 8; i++) b[7 - i] = bitq.pop_front();
      send(OP_DATA, b);
    end
    send(OP_DATA, 8'hA5);
    while (sb.pending()) send(OP_CONT, 8'h00);
    // Random part: mostly well-formed tokens, with noise and stray items.
    while (sent < 410) begin
      if (sb.pending()) begin
        if ($urandom_range(0, 7) == 0) send(OP_DATA, 8'($urandom));
        else send(OP_CONT, 8'($urandom));
      end else if ($urandom_range(0, 19) == 0) send(OP_CONT, 8'($urandom));
      else if (bitq.size() >= 8) flush_bytes();
      else random_token();
    end
    in_valid <= 0;
    while (sb.due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: files.f
sv/mppc_pkg.sv
sv/mppc_ram.sv
sv/mppc_front.sv
sv/mppc_back.sv
sv/mppc_variant_lz_decompressor.sv
test/testbench.sv
